// ===== hdl/egf_pkg.sv =====
`default_nettype none
package egf_pkg;
    localparam int MAX_EXTENTS = 64;
    localparam int IDX_W = $clog2(MAX_EXTENTS);
    localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
    localparam logic [63:0] DATA_START_RESET = 64'd4096;
    localparam logic STATUS_OK = 1'b0;
    localparam logic STATUS_CORRUPT = 1'b1;

    typedef struct packed {
        logic [63:0] extent_offset;
        logic [63:0] extent_length;
        logic        last_extent;
    } ext_t;

    typedef struct packed {
        logic [63:0] hole_offset;
        logic [63:0] hole_length;
        logic        has_hole;
        logic        status;
        logic        last_result;
    } res_t;

    typedef enum logic [1:0] {ST_FILL, ST_SHIFT, ST_SCAN, ST_EMIT} bk_state_t;
endpackage
`default_nettype wire

// ===== hdl/egf_if.sv =====
`default_nettype none
interface egf_ext_if;
    import egf_pkg::*;
    logic valid;
    logic ready;
    ext_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface egf_res_if;
    import egf_pkg::*;
    logic valid;
    logic ready;
    res_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== hdl/extent_gap_finder.sv =====
// Sorting: an extent that leaves the queue is placed by shifting larger entries up one per step;
// the next extent waits until it is placed. An extent that meets a full set is dropped.
// The scan walks the stored extents, pausing while the output is held; an overlap after a held
// hole sends it and revisits the entry; a hole waits for the next hole, an overlap or the end.
// Reset (rst_n low, asynchronous) empties the set and loads data_start with 4096.
`default_nettype none
module extent_gap_finder
    import egf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,
    egf_ext_if.sink          in_ch,
    egf_res_if.source        out_ch
);
    logic [63:0] data_start_reg;
    ext_t        q_data;
    logic        q_valid, q_pop;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) data_start_reg <= DATA_START_RESET;
        else if (cfg_we) data_start_reg <= cfg_wdata;
    end

    egf_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                       .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop));

    egf_back u_back (.clk(clk), .rst_n(rst_n), .data_start(data_start_reg),
                     .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
                     .out_ch(out_ch));
endmodule
`default_nettype wire

// ===== hdl/egf_front.sv =====
`default_nettype none
// Input queue: two-entry FIFO between the port and the sorter
module egf_front
    import egf_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    egf_ext_if.sink   in_ch,
    output ext_t      q_data,
    output logic      q_valid,
    input  wire logic q_pop
);
    ext_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push = in_ch.valid && in_ch.ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data = mem_reg[rp_reg];

    // payload storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_ch.payload;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (q_pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule
`default_nettype wire

// ===== hdl/egf_back.sv =====
`default_nettype none
// Sorter and scanner: stable insertion into a memory, then a gap scan
module egf_back
    import egf_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [63:0] data_start,
    input  ext_t             q_data,
    input  wire logic        q_valid,
    output logic             q_pop,
    egf_res_if.source        out_ch
);
    logic [63:0] off_mem [MAX_EXTENTS];
    logic [63:0] len_mem [MAX_EXTENTS];

    bk_state_t   state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] pos_inc;
    logic        scan_done;
    logic [63:0] new_off_reg, new_off_next, new_len_reg, new_len_next;
    logic        last_reg, last_next;
    logic [63:0] rd_off_reg, rd_len_reg;
    logic [IDX_W-1:0] rd_addr;
    logic        rd_valid_reg, rd_valid_next;
    logic [63:0] end_reg, end_next;
    logic        any_reg, any_next;
    logic [63:0] hole_off_reg, hole_off_next, hole_len_reg, hole_len_next;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0] wr_off, wr_len;
    res_t        res_reg, res_next;
    logic        ovalid_reg, ovalid_next;
    logic        out_free;

    assign out_free = !ovalid_reg || out_ch.ready;
    assign out_ch.valid = ovalid_reg;
    assign out_ch.payload = res_reg;
    assign pos_inc = pos_reg + CNT_W'(1);
    assign scan_done = (pos_inc == count_reg);

    // memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            off_mem[wr_addr] <= wr_off;
            len_mem[wr_addr] <= wr_len;
        end
        rd_off_reg <= off_mem[rd_addr];
        rd_len_reg <= len_mem[rd_addr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (q_valid)
                begin
                    if (count_reg == CNT_W'(MAX_EXTENTS))
                        state_next = q_data.last_extent ? ST_SCAN : ST_FILL;
                    else
                        state_next = ST_SHIFT;
                end
            end
            ST_SHIFT:
            begin
                if (pos_reg == '0 || (rd_valid_reg && rd_off_reg <= new_off_reg))
                    state_next = last_reg ? ST_SCAN : ST_FILL;
            end
            ST_SCAN:
            begin
                if (rd_valid_reg && out_free)
                begin
                    if (rd_off_reg < end_reg)
                    begin
                        if (!any_reg)
                            state_next = ST_FILL;
                    end
                    else if (scan_done)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free) state_next = ST_FILL;
            end
            default: state_next = ST_FILL;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        new_off_next  = new_off_reg;
        new_len_next  = new_len_reg;
        last_next     = last_reg;
        rd_valid_next = 1'b0;
        end_next      = end_reg;
        any_next      = any_reg;
        hole_off_next = hole_off_reg;
        hole_len_next = hole_len_reg;
        res_next      = res_reg;
        ovalid_next   = ovalid_reg && !out_ch.ready;
        q_pop         = 1'b0;
        wr_en         = 1'b0;
        wr_addr       = pos_reg[IDX_W-1:0];
        wr_off        = rd_off_reg;
        wr_len        = rd_len_reg;
        rd_addr       = pos_reg[IDX_W-1:0];
        case (state_reg)
            ST_FILL:
            begin
                q_pop = q_valid;
                end_next = data_start;
                any_next = 1'b0;
                if (q_valid)
                begin
                    new_off_next = q_data.extent_offset;
                    new_len_next = q_data.extent_length;
                    last_next    = q_data.last_extent;
                    pos_next     = count_reg;
                    rd_addr      = IDX_W'(count_reg - 1'b1);
                    rd_valid_next = (count_reg != '0);
                    if (count_reg == CNT_W'(MAX_EXTENTS))
                    begin
                        // store full: drop the extent, scan primes its own read
                        pos_next = '0;
                        rd_addr = '0;
                        rd_valid_next = 1'b0;
                    end
                end
            end
            ST_SHIFT:
            begin
                // rd holds entry pos-1 when rd_valid
                if (pos_reg == '0 || (rd_valid_reg && rd_off_reg <= new_off_reg))
                begin
                    wr_en  = 1'b1;
                    wr_off = new_off_reg;
                    wr_len = new_len_reg;
                    count_next = count_reg + 1'b1;
                    pos_next = '0;
                    rd_addr = '0;
                    // entry 0 may be written now, so the scan reads it next cycle
                    rd_valid_next = 1'b0;
                end
                else
                begin
                    wr_en = 1'b1;
                    pos_next = pos_reg - 1'b1;
                    rd_addr = IDX_W'(pos_reg - 2'd2);
                    rd_valid_next = (pos_reg != CNT_W'(1));
                end
            end
            ST_SCAN:
            begin
                // a hole is held until the next hole, an overlap or the end tells its last flag
                rd_valid_next = 1'b1;
                if (rd_valid_reg && out_free)
                begin
                    if (rd_off_reg < end_reg)
                    begin
                        if (any_reg)
                        begin
                            // send the held hole, then revisit this entry
                            res_next = '{hole_off_reg, hole_len_reg, 1'b1, STATUS_OK, 1'b0};
                            ovalid_next = 1'b1;
                            any_next = 1'b0;
                        end
                        else
                        begin
                            res_next = '{64'd0, 64'd0, 1'b0, STATUS_CORRUPT, 1'b1};
                            ovalid_next = 1'b1;
                            count_next = '0;
                            pos_next = '0;
                            rd_valid_next = 1'b0;
                        end
                    end
                    else
                    begin
                        if (rd_off_reg > end_reg)
                        begin
                            if (any_reg)
                            begin
                                res_next = '{hole_off_reg, hole_len_reg, 1'b1, STATUS_OK,
                                             1'b0};
                                ovalid_next = 1'b1;
                            end
                            any_next = 1'b1;
                            hole_off_next = end_reg;
                            hole_len_next = rd_off_reg - end_reg;
                        end
                        end_next = rd_off_reg + rd_len_reg;
                        pos_next = pos_inc;
                        rd_addr = pos_inc[IDX_W-1:0];
                        rd_valid_next = !scan_done;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (any_reg)
                    begin
                        res_next = '{hole_off_reg, hole_len_reg, 1'b1, STATUS_OK, 1'b1};
                    end
                    else
                    begin
                        res_next = '{64'd0, 64'd0, 1'b0, STATUS_OK, 1'b1};
                    end
                    ovalid_next = 1'b1;
                    any_next = 1'b0;
                    count_next = '0;
                    pos_next = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_FILL;
            count_reg    <= '0;
            pos_reg      <= '0;
            rd_valid_reg <= 1'b0;
            ovalid_reg   <= 1'b0;
            any_reg      <= 1'b0;
            end_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            rd_valid_reg <= rd_valid_next;
            ovalid_reg   <= ovalid_next;
            any_reg      <= any_next;
            end_reg      <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_off_reg  <= new_off_next;
        new_len_reg  <= new_len_next;
        last_reg     <= last_next;
        hole_off_reg <= hole_off_next;
        hole_len_reg <= hole_len_next;
        res_reg      <= res_next;
    end
endmodule
`default_nettype wire

// ===== hdl/egf_checker.sv =====
`default_nettype none
module egf_checker
    import egf_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic out_valid,
    input wire logic out_ready,
    input res_t      out_payload
);
    // held result does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_payload)) else $error("payload moved");
    a_stay: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("valid dropped");
    // corrupt status is always final and carries no hole
    a_corrupt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.status |-> out_payload.last_result && !out_payload.has_hole)
        else $error("bad corrupt result");
    a_nohole: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_payload.has_hole |-> out_payload.hole_length == 64'd0)
        else $error("stray length");
endmodule

bind extent_gap_finder egf_checker u_chk (.clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_payload(out_ch.payload));
`default_nettype wire
